>>> rtl/rset_pkg.sv
`default_nettype none
package rset_pkg;

    localparam int DEF_VALUE_COUNT = 1024;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 10;
    localparam int DRAW_W   = 10;
    localparam int STATUS_W = 2;
    localparam int RESULT_W = 10;
    localparam int COUNT_W  = 11;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RANDOM   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clear;     // write one map entry of the clearing pass
        logic capture;   // input transaction taken, issue first reads
        logic exec;      // decide, first writes
        logic fin;       // second map write, random pick data back
        logic load_fin;  // result register takes the freshly finished result
        logic load_wait; // result register takes the held result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } stat_t;

    function automatic int floor_log2(input int x);
        int n;
        int v;
        n = 0;
        v = x;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rset_ctrl.sv
`default_nettype none
module rset_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rset_pkg::stat_t stat,
    output rset_pkg::cmd_t      cmd
);
    import rset_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load_fin = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_wait = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rset_dp.sv
`default_nettype none
module rset_dp #(
    parameter int VALUE_COUNT = rset_pkg::DEF_VALUE_COUNT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rset_pkg::cmd_t                  cmd,
    output rset_pkg::stat_t                      stat,
    input  wire logic [rset_pkg::ACTION_W-1:0]   in_action,
    input  wire logic [rset_pkg::VALUE_W-1:0]    in_value,
    input  wire logic [rset_pkg::DRAW_W-1:0]     in_draw,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [rset_pkg::STATUS_W-1:0]        out_status,
    output logic [rset_pkg::RESULT_W-1:0]        out_result,
    output logic [rset_pkg::COUNT_W-1:0]         out_count
);
    import rset_pkg::*;

    localparam int IDX_W  = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
    localparam int CNT_W  = $clog2(VALUE_COUNT + 1);
    localparam int PROD_W = DRAW_W + CNT_W;
    localparam int SHIFT  = floor_log2(VALUE_COUNT);
    localparam int MAP_W  = IDX_W + 1;

    // storage
    logic [VALUE_W-1:0] elem_mem [VALUE_COUNT];
    logic [MAP_W-1:0]   map_mem  [VALUE_COUNT];   // {member, slot}

    logic [VALUE_W-1:0] elem_rd_reg;
    logic [MAP_W-1:0]   map_rd_reg;

    // request and control registers
    logic [ACTION_W-1:0] action_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [IDX_W-1:0]    vidx_reg;
    logic                in_range_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                remove_reg;
    logic [RESULT_W-1:0] result_pend_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [RESULT_W-1:0] out_result_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                map_hit;
    logic [IDX_W-1:0]    map_slot;
    logic                add_ok;
    logic                rem_ok;
    logic [PROD_W-1:0]   scaled;
    logic [IDX_W-1:0]    pick_idx;
    logic [RESULT_W-1:0] result_fin;

    logic                elem_we;
    logic [IDX_W-1:0]    elem_waddr;
    logic [VALUE_W-1:0]  elem_wdata;
    logic                elem_re;
    logic [IDX_W-1:0]    elem_raddr;
    logic                map_we;
    logic [IDX_W-1:0]    map_waddr;
    logic [MAP_W-1:0]    map_wdata;

    assign map_hit  = map_rd_reg[IDX_W];
    assign map_slot = map_rd_reg[IDX_W-1:0];
    assign add_ok   = in_range_reg && (count_reg < CNT_W'(VALUE_COUNT)) && !map_hit;
    assign rem_ok   = in_range_reg && map_hit && (count_reg != '0);

    // slot = (draw * count) >> log2, saturated to the last member
    assign scaled = prod_reg >> SHIFT;
    always_comb
    begin
        if (scaled >= PROD_W'(count_reg))
        begin
            pick_idx = IDX_W'(count_reg - CNT_W'(1));
        end
        else
        begin
            pick_idx = IDX_W'(scaled);
        end
    end

    assign elem_re    = cmd.capture || cmd.exec;
    assign elem_raddr = cmd.capture ? IDX_W'(count_reg - CNT_W'(1)) : pick_idx;

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        elem_we     = 1'b0;
        elem_waddr  = IDX_W'(count_reg);
        elem_wdata  = value_reg;
        map_we      = 1'b0;
        map_waddr   = vidx_reg;
        map_wdata   = '0;
        if (cmd.clear)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
        end
        else if (cmd.exec)
        begin
            unique case (action_reg)
                ACT_ADD:
                begin
                    if (!in_range_reg || (count_reg >= CNT_W'(VALUE_COUNT)))
                    begin
                        status_next = ST_ABSENT;
                    end
                    else if (map_hit)
                    begin
                        status_next = ST_PRESENT;
                    end
                    if (add_ok)
                    begin
                        elem_we    = 1'b1;
                        map_we     = 1'b1;
                        map_wdata  = {1'b1, IDX_W'(count_reg)};
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (rem_ok)
                    begin
                        // last member moves into the freed slot
                        elem_we    = 1'b1;
                        elem_waddr = map_slot;
                        elem_wdata = elem_rd_reg;
                        map_we     = 1'b1;
                        map_waddr  = IDX_W'(elem_rd_reg);
                        map_wdata  = {1'b1, map_slot};
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                ACT_CONTAINS:
                begin
                    status_next = (in_range_reg && map_hit) ? ST_OK : ST_ABSENT;
                end
                ACT_RANDOM:
                begin
                    status_next = (count_reg == '0) ? ST_EMPTY : ST_OK;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (cmd.fin && remove_reg)
        begin
            // removed value's entry goes absent after the repoint
            map_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rd_reg <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.capture)
        begin
            map_rd_reg <= map_mem[IDX_W'(in_value)];
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= in_action;
            value_reg    <= in_value;
            vidx_reg     <= IDX_W'(in_value);
            in_range_reg <= (32'(in_value) < 32'(VALUE_COUNT));
            prod_reg     <= PROD_W'(in_draw) * PROD_W'(count_reg);
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
        end
        if (cmd.fin)
        begin
            result_pend_reg <= result_fin;
        end
    end

    assign result_fin = ((action_reg == ACT_RANDOM) && (status_reg == ST_OK)) ?
                        elem_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remove_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg  <= count_next;
                remove_reg <= (action_reg == ACT_REMOVE) && rem_ok;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.load_fin || cmd.load_wait)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_fin || cmd.load_wait)
        begin
            out_status_reg <= status_reg;
            out_result_reg <= cmd.load_fin ? result_fin : result_pend_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.clear_done = (clr_cnt_reg == IDX_W'(VALUE_COUNT - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_result = out_result_reg;
    assign out_count  = COUNT_W'(out_count_reg);

endmodule
`default_nettype wire

>>> rtl/randomized_set_table.sv
// Randomized set table: a set of values 0 .. VALUE_COUNT-1 with add, remove,
// membership test and random pick.
// Input stream (s_axis): one request per transaction; action, value and a
// random draw. Output stream (m_axis): exactly one result per request with
// status, picked value (random pick only) and the member count afterwards.
// Sequence: a request is taken in the idle state, passes through the exec
// and finish states, and its result then lands in the output register once
// that is free; the next request is taken only after that. The remove path
// sets this order: a registered read of the slot map and of the last element,
// then a move write, then a second slot map write, one map write port per cycle.
// Reset: s_axis_tready stays low for VALUE_COUNT cycles after reset while
// every slot map entry is cleared to absent, one entry per cycle.
// Stall: the output register holds a result until m_axis_tready; while it
// waits one more request can be accepted and processed, then the block
// holds that result internally until the output register frees up.
`default_nettype none
module randomized_set_table #(
    parameter int VALUE_COUNT = rset_pkg::DEF_VALUE_COUNT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // action[1:0], value[11:2], random_draw[21:12], zero pad
    input  wire logic [rset_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // status[1:0], result_value[11:2], count[22:12], zero pad
    output logic [rset_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import rset_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] out_status;
    logic [RESULT_W-1:0] out_result;
    logic [COUNT_W-1:0]  out_count;

    rset_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rset_dp #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_axis_tdata[1:0]),
        .in_value   (s_axis_tdata[11:2]),
        .in_draw    (s_axis_tdata[21:12]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_result (out_result),
        .out_count  (out_count)
    );

    assign m_axis_tdata = {1'b0, out_count, out_result, out_status};

endmodule
`default_nettype wire

>>> dv/randomized_set_table_tb.sv
`default_nettype none
module randomized_set_table_tb;
    import rset_pkg::*;

    localparam int VALUE_COUNT = DEF_VALUE_COUNT;
    localparam int DRAW_SHIFT  = $clog2(VALUE_COUNT);
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RESULT_W-1:0] picked;
        logic [COUNT_W-1:0]  count;
    } set_response_t;

    // Shadow copy of the set plus the queue of responses still owed by the block.
    class set_table_scoreboard;
        logic [VALUE_W-1:0] elems [VALUE_COUNT];
        int unsigned        slot_of [VALUE_COUNT];
        bit                 present [VALUE_COUNT];
        int unsigned        members;
        set_response_t      owed_responses [$];
        int unsigned        errors;
        int unsigned        checked;

        function new();
            members = 0;
            errors  = 0;
            checked = 0;
            for (int i = 0; i < VALUE_COUNT; i++)
            begin
                elems[i]   = '0;
                slot_of[i] = 0;
                present[i] = 1'b0;
            end
        endfunction

        function void accept_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                                     logic [DRAW_W-1:0] draw);
            set_response_t resp;
            int unsigned   pos;
            int unsigned   moved;
            longint unsigned slot;
            resp.status = ST_OK;
            resp.picked = '0;
            case (act)
                ACT_ADD:
                begin
                    if (members >= VALUE_COUNT)
                        resp.status = ST_ABSENT;
                    else if (present[val])
                        resp.status = ST_PRESENT;
                    else
                    begin
                        elems[members] = val;
                        slot_of[val]   = members;
                        present[val]   = 1'b1;
                        members++;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!present[val] || members == 0)
                        resp.status = ST_ABSENT;
                    else
                    begin
                        // last member fills the hole; also right when val is the last
                        pos            = slot_of[val];
                        moved          = elems[members - 1];
                        elems[pos]     = moved[VALUE_W-1:0];
                        slot_of[moved] = pos;
                        present[val]   = 1'b0;
                        slot_of[val]   = 0;
                        members--;
                    end
                end
                ACT_CONTAINS:
                    resp.status = present[val] ? ST_OK : ST_ABSENT;
                default:
                begin
                    if (members == 0)
                        resp.status = ST_EMPTY;
                    else
                    begin
                        slot = (longint'(draw) * members) >> DRAW_SHIFT;
                        if (slot >= members)
                            slot = members - 1;
                        resp.picked = elems[slot];
                    end
                end
            endcase
            resp.count = members[COUNT_W-1:0];
            owed_responses.push_back(resp);
        endfunction

        function void check_response(logic [OUT_TDATA_W-1:0] data);
            set_response_t want;
            logic [STATUS_W-1:0] got_status;
            logic [RESULT_W-1:0] got_picked;
            logic [COUNT_W-1:0]  got_count;
            got_status = data[STATUS_W-1:0];
            got_picked = data[STATUS_W +: RESULT_W];
            got_count  = data[STATUS_W+RESULT_W +: COUNT_W];
            checked++;
            if (owed_responses.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, tdata %h", $time, data);
                return;
            end
            want = owed_responses.pop_front();
            if (got_status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            end
            if (got_picked !== want.picked)
            begin
                errors++;
                $display("%0t: result_value expected %0d actual %0d", $time, want.picked,
                         got_picked);
            end
            if (got_count !== want.count)
            begin
                errors++;
                $display("%0t: count expected %0d actual %0d", $time, want.count, got_count);
            end
        endfunction

        function logic [VALUE_W-1:0] any_member();
            return elems[$urandom_range(0, members - 1)];
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    set_table_scoreboard board;
    bit                  calm;
    bit                  long_hold_done;
    int                  stall_left;

    randomized_set_table #(
        .VALUE_COUNT(VALUE_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 94)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                                input logic [DRAW_W-1:0] draw);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 40)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-ACTION_W-VALUE_W-DRAW_W){1'b0}}, draw, val, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.accept_request(act, val, draw);
        // switch idling on and off in stretches
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
    endtask

    task automatic send_random_request();
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
        logic [DRAW_W-1:0]   draw;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            act = ACT_ADD;
        else if (r < 65)
            act = ACT_REMOVE;
        else if (r < 80)
            act = ACT_CONTAINS;
        else
            act = ACT_RANDOM;
        r = $urandom_range(0, 99);
        if (r < 40 && board.members > 0)
            val = board.any_member();
        else if (r < 85)
            val = VALUE_W'($urandom_range(0, 63));
        else
            val = VALUE_W'($urandom_range(0, VALUE_COUNT - 1));
        r = $urandom_range(0, 9);
        if (r == 0)
            draw = '0;
        else if (r == 1)
            draw = '1;
        else
            draw = DRAW_W'($urandom_range(0, (1 << DRAW_W) - 1));
        send_request(act, val, draw);
    endtask

    // receiver: random stalls plus one long hold-off to back the block up
    initial
    begin
        m_axis_tready  = 1'b0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_response(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!long_hold_done && board.checked >= 150)
                begin
                    long_hold_done = 1'b1;
                    stall_left     = LONG_HOLD;
                end
                else if (!calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("** randomized_set_table: FAILED **");
        $finish;
    end

    initial
    begin
        board         = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty set, extremes, duplicate add, removal of first and last slot
        send_request(ACT_RANDOM,   10'd0,    10'd1023);
        send_request(ACT_REMOVE,   10'd5,    10'd0);
        send_request(ACT_CONTAINS, 10'd0,    10'd0);
        send_request(ACT_ADD,      10'd0,    10'd0);
        send_request(ACT_ADD,      10'd1023, 10'd1023);
        send_request(ACT_ADD,      10'd0,    10'd0);
        send_request(ACT_CONTAINS, 10'd1023, 10'd0);
        send_request(ACT_CONTAINS, 10'd512,  10'd0);
        send_request(ACT_RANDOM,   10'd0,    10'd0);
        send_request(ACT_RANDOM,   10'd1023, 10'd1023);
        send_request(ACT_ADD,      10'd341,  10'd0);
        send_request(ACT_ADD,      10'd682,  10'd0);
        send_request(ACT_ADD,      10'd1,    10'd0);
        send_request(ACT_REMOVE,   10'd0,    10'd0);
        send_request(ACT_REMOVE,   10'd1,    10'd0);
        send_request(ACT_REMOVE,   10'd1,    10'd0);
        send_request(ACT_RANDOM,   10'd0,    10'd512);
        send_request(ACT_REMOVE,   10'd341,  10'd0);
        send_request(ACT_REMOVE,   10'd682,  10'd0);
        send_request(ACT_REMOVE,   10'd1023, 10'd0);
        send_request(ACT_RANDOM,   10'd1023, 10'd0);
        send_request(ACT_CONTAINS, 10'd1023, 10'd1023);

        repeat (478)
            send_random_request();
        s_axis_tvalid <= 1'b0;

        while (board.owed_responses.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("** randomized_set_table: PASSED **");
        else
            $display("** randomized_set_table: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
